// ----- rtl/dstwr_pkg.sv -----
//------------------------------------------------------------------------------
// dstwr_pkg
// Shared types and constants of the double-sided two-way ranging responder.
//------------------------------------------------------------------------------
`default_nettype none

package dstwr_pkg;

	localparam int STAMP_W     = 40;
	localparam int FRAC_W      = 8;
	localparam int TX_W        = 32;
	localparam int TX_SHIFT    = STAMP_W - TX_W;
	localparam int MM_W        = 20;
	localparam int TOF_W       = 48;
	localparam int DIST_W      = 32;
	localparam int SCALE_SHIFT = FRAC_W + 16;
	localparam int PROD_W      = 2 * STAMP_W;
	localparam int DVD_W       = PROD_W + FRAC_W;
	localparam int DEN_W       = STAMP_W + 2;
	localparam int SCL_W       = TOF_W + MM_W;
	localparam int DSH_W       = SCL_W + 1 - SCALE_SHIFT;
	localparam int CNT_W       = $clog2(DVD_W + 1);
	localparam int IDX_W       = 8;
	localparam int CFG_W       = 32;

	localparam logic [TX_W-1:0]  REPLY_DELAY_RST = 32'd57508200;
	localparam logic [MM_W-1:0]  MM_PER_TICK_RST = 20'd307385;
	localparam logic [IDX_W-1:0] REG_REPLY_DELAY = 8'd0;
	localparam logic [IDX_W-1:0] REG_MM_PER_TICK = 8'd1;

	localparam logic [7:0] FT_POLL    = 8'h01;
	localparam logic       KIND_GOOD  = 1'b0;
	localparam logic       RK_RESP    = 1'b0;
	localparam logic       RK_RANGE   = 1'b1;
	localparam logic [TX_W-1:0] TX_EVEN_MASK = 32'hFFFFFFFE;

	typedef struct packed {
		logic               kind;
		logic [7:0]         frame_type;
		logic [7:0]         seq_num;
		logic [STAMP_W-1:0] rx_stamp;
		logic [STAMP_W-1:0] poll_tx_stamp;
		logic [STAMP_W-1:0] resp_rx_stamp;
		logic [STAMP_W-1:0] final_tx_stamp;
	} frame_t;

	typedef struct packed {
		logic                     result_kind;
		logic [7:0]               reply_seq;
		logic [TX_W-1:0]          delayed_tx_time;
		logic [STAMP_W-1:0]       echo_poll_rx;
		logic [STAMP_W-1:0]       planned_resp_tx;
		logic signed [TOF_W-1:0]  tof_q8;
		logic signed [DIST_W-1:0] distance_mm;
	} result_t;

	typedef struct packed {
		logic               is_range;
		logic [7:0]         seq;
		logic [TX_W-1:0]    dt;
		logic [STAMP_W-1:0] t2;
		logic [STAMP_W-1:0] t3;
		logic [STAMP_W-1:0] ra;
		logic [STAMP_W-1:0] rb;
		logic [STAMP_W-1:0] da;
		logic [STAMP_W-1:0] db;
	} job_t;

endpackage

`default_nettype wire

// ----- rtl/dstwr_front.sv -----
//------------------------------------------------------------------------------
// dstwr_front
// Classifies receive events, keeps the exchange state and builds jobs.
//------------------------------------------------------------------------------
`default_nettype none

module dstwr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          frame_valid,
	output logic                               frame_stall,
	input  wire dstwr_pkg::frame_t             frame,
	input  wire logic [dstwr_pkg::TX_W-1:0]    reply_delay,
	input  wire logic                          q_full,
	output logic                               q_push,
	output dstwr_pkg::job_t                    q_job
);

	logic                             awaiting_q;
	logic [dstwr_pkg::STAMP_W-1:0]    poll_rx_q;
	logic [dstwr_pkg::STAMP_W-1:0]    resp_tx_q;
	logic [dstwr_pkg::STAMP_W:0]      sum;
	logic [dstwr_pkg::TX_W-1:0]       dt;
	logic [dstwr_pkg::STAMP_W-1:0]    t3;
	logic                             accept;
	logic                             is_poll;

	always_comb begin
		sum = {1'b0, frame.rx_stamp} + (dstwr_pkg::STAMP_W+1)'(reply_delay);
		dt = sum[dstwr_pkg::TX_SHIFT +: dstwr_pkg::TX_W];
		t3 = dstwr_pkg::STAMP_W'(dt & dstwr_pkg::TX_EVEN_MASK) << dstwr_pkg::TX_SHIFT;
		accept = frame_valid && !q_full;
		is_poll = (frame.frame_type == dstwr_pkg::FT_POLL);
		frame_stall = q_full;
		q_push = accept && (frame.kind == dstwr_pkg::KIND_GOOD) && (awaiting_q || is_poll);
		q_job.is_range = awaiting_q;
		q_job.seq = frame.seq_num;
		q_job.dt = dt;
		q_job.t2 = frame.rx_stamp;
		q_job.t3 = t3;
		q_job.ra = frame.resp_rx_stamp - frame.poll_tx_stamp;
		q_job.rb = frame.rx_stamp - resp_tx_q;
		q_job.da = frame.final_tx_stamp - frame.resp_rx_stamp;
		q_job.db = resp_tx_q - poll_rx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			poll_rx_q <= '0;
			resp_tx_q <= '0;
		end else if (accept) begin
			if (frame.kind != dstwr_pkg::KIND_GOOD || awaiting_q) begin
				awaiting_q <= 1'b0;
			end else if (is_poll) begin
				awaiting_q <= 1'b1;
				poll_rx_q <= frame.rx_stamp;
				resp_tx_q <= t3;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dstwr_queue.sv -----
//------------------------------------------------------------------------------
// dstwr_queue
// Two-entry job queue between the front and the arithmetic back end.
//------------------------------------------------------------------------------
`default_nettype none

module dstwr_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dstwr_pkg::job_t push_job,
	output logic                 full,
	input  wire logic            pop,
	output logic                 avail,
	output dstwr_pkg::job_t      head
);

	dstwr_pkg::job_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("push into full queue");

endmodule

`default_nettype wire

// ----- rtl/dstwr_back.sv -----
//------------------------------------------------------------------------------
// dstwr_back
// Runs jobs: passes responses out, computes tof and distance with a serial
// multiplier and a one-bit-per-cycle restoring divider.
//------------------------------------------------------------------------------
`default_nettype none

module dstwr_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_avail,
	input  wire dstwr_pkg::job_t             q_head,
	output logic                             q_pop,
	input  wire logic [dstwr_pkg::MM_W-1:0]  mm_per_tick,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output dstwr_pkg::result_t               result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SUB   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_CLAMP = 3'd4;
	localparam logic [2:0] ST_SCL   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	localparam int SW = dstwr_pkg::STAMP_W;
	localparam int TW = dstwr_pkg::TOF_W;
	localparam int MW = dstwr_pkg::MM_W;

	logic [2:0]                        state_q;
	logic [dstwr_pkg::CNT_W-1:0]       cnt_q;
	logic [SW-1:0]                     ra_q;
	logic [SW-1:0]                     da_q;
	logic [dstwr_pkg::PROD_W-1:0]      p1_q;
	logic [dstwr_pkg::PROD_W-1:0]      p2_q;
	logic [dstwr_pkg::DEN_W-1:0]       den_q;
	logic [dstwr_pkg::DEN_W-1:0]       rem_q;
	logic [dstwr_pkg::DVD_W-1:0]       dvd_q;
	logic                              neg_q;
	logic [TW-1:0]                     tmag_q;
	logic [dstwr_pkg::SCL_W-1:0]       sc_q;
	dstwr_pkg::result_t                res_q;
	dstwr_pkg::result_t                result_q;
	logic                              result_valid_q;

	logic [dstwr_pkg::DEN_W-1:0]       den;
	logic [SW:0]                       s1;
	logic [SW:0]                       s2;
	logic [dstwr_pkg::PROD_W-1:0]      mag;
	logic [dstwr_pkg::DEN_W:0]         r;
	logic                              ge;
	logic [TW-1:0]                     tcap;
	logic [TW:0]                       s3;
	logic [dstwr_pkg::SCL_W:0]         dm;
	logic [dstwr_pkg::DSH_W-1:0]       dsh;
	logic [dstwr_pkg::DSH_W-1:0]       dcap;
	logic [dstwr_pkg::DIST_W-1:0]      dmag;
	logic                              out_free;

	always_comb begin
		den = dstwr_pkg::DEN_W'(q_head.ra) + dstwr_pkg::DEN_W'(q_head.rb)
			+ dstwr_pkg::DEN_W'(q_head.da) + dstwr_pkg::DEN_W'(q_head.db);
		s1 = {1'b0, p1_q[dstwr_pkg::PROD_W-1:SW]} + (p1_q[0] ? {1'b0, ra_q} : '0);
		s2 = {1'b0, p2_q[dstwr_pkg::PROD_W-1:SW]} + (p2_q[0] ? {1'b0, da_q} : '0);
		mag = (p1_q >= p2_q) ? (p1_q - p2_q) : (p2_q - p1_q);
		r = {rem_q, dvd_q[dstwr_pkg::DVD_W-1]};
		ge = (r >= {1'b0, den_q});
		tcap = neg_q ? (TW'(1) << (TW-1)) : ((TW'(1) << (TW-1)) - TW'(1));
		s3 = {1'b0, sc_q[dstwr_pkg::SCL_W-1:MW]} + (sc_q[0] ? {1'b0, tmag_q} : '0);
		dm = {1'b0, sc_q} + (neg_q ? ((dstwr_pkg::SCL_W+1)'(1) << dstwr_pkg::SCALE_SHIFT)
			- (dstwr_pkg::SCL_W+1)'(1) : '0);
		dsh = dm[dstwr_pkg::SCALE_SHIFT +: dstwr_pkg::DSH_W];
		dcap = neg_q ? (dstwr_pkg::DSH_W'(1) << (dstwr_pkg::DIST_W-1))
			: ((dstwr_pkg::DSH_W'(1) << (dstwr_pkg::DIST_W-1)) - dstwr_pkg::DSH_W'(1));
		dmag = dstwr_pkg::DIST_W'((dsh > dcap) ? dcap : dsh);
		out_free = !result_valid_q || !result_stall;
		q_pop = (state_q == ST_IDLE) && q_avail;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ra_q <= q_head.ra;
				da_q <= q_head.da;
				p1_q <= {{SW{1'b0}}, q_head.rb};
				p2_q <= {{SW{1'b0}}, q_head.db};
				den_q <= den;
				res_q.result_kind <= q_head.is_range ? dstwr_pkg::RK_RANGE : dstwr_pkg::RK_RESP;
				res_q.reply_seq <= q_head.is_range ? '0 : q_head.seq;
				res_q.delayed_tx_time <= q_head.is_range ? '0 : q_head.dt;
				res_q.echo_poll_rx <= q_head.is_range ? '0 : q_head.t2;
				res_q.planned_resp_tx <= q_head.is_range ? '0 : q_head.t3;
				res_q.tof_q8 <= '0;
				res_q.distance_mm <= '0;
			end
			ST_MUL: begin
				p1_q <= {s1, p1_q[SW-1:1]};
				p2_q <= {s2, p2_q[SW-1:1]};
			end
			ST_SUB: begin
				neg_q <= (p1_q < p2_q);
				dvd_q <= dstwr_pkg::DVD_W'(mag) << dstwr_pkg::FRAC_W;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? dstwr_pkg::DEN_W'(r - {1'b0, den_q}) : r[dstwr_pkg::DEN_W-1:0];
				dvd_q <= {dvd_q[dstwr_pkg::DVD_W-2:0], ge};
			end
			ST_CLAMP: begin
				tmag_q <= (dvd_q[dstwr_pkg::DVD_W-1:TW-1] != '0) ? tcap : dvd_q[TW-1:0];
				sc_q <= {{TW{1'b0}}, mm_per_tick};
			end
			ST_SCL: begin
				sc_q <= {s3, sc_q[MW-1:1]};
			end
			ST_FIN: begin
				res_q.tof_q8 <= neg_q ? (TW'(0) - tmag_q) : tmag_q;
				res_q.distance_mm <= neg_q ? (dstwr_pkg::DIST_W'(0) - dmag) : dmag;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			result_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_avail) begin
						if (!q_head.is_range) begin
							state_q <= ST_OUT;
						end else if (den != '0) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == dstwr_pkg::CNT_W'(SW - 1)) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == dstwr_pkg::CNT_W'(dstwr_pkg::DVD_W - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					cnt_q <= '0;
					state_q <= ST_SCL;
				end
				ST_SCL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == dstwr_pkg::CNT_W'(MW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < dstwr_pkg::CNT_W'(dstwr_pkg::DVD_W)))
		else $error("divider ran past its last step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q < dstwr_pkg::CNT_W'(SW)))
		else $error("multiplier ran past its last step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_head.is_range) |=> (state_q == ST_OUT))
		else $error("response word popped but not staged");

endmodule

`default_nettype wire

// ----- rtl/ds_twr_responder_ranging.sv -----
// Responder for double-sided two-way ranging. A good poll frame while idle yields
// a response word once it has passed the job queue and the back end; the next good
// frame is the final and yields a ranging word after the 40-step serial multiplier,
// the 88-step one-bit restoring divider and the 20-step scale multiplier. A two-entry
// job queue lets frames keep arriving while the divider runs, until the queue is full.
// A final whose round-trip sum is zero, and any receive error, gives no word.
//------------------------------------------------------------------------------
// ds_twr_responder_ranging
// Top level: configuration registers, front, job queue and arithmetic back end.
//------------------------------------------------------------------------------
`default_nettype none

module ds_twr_responder_ranging (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          frame_valid,
	output logic                               frame_stall,
	input  wire dstwr_pkg::frame_t             frame,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output dstwr_pkg::result_t                 result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dstwr_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [dstwr_pkg::CFG_W-1:0]   cfg_data
);

	logic [dstwr_pkg::TX_W-1:0] reply_delay_q;
	logic [dstwr_pkg::MM_W-1:0] mm_per_tick_q;
	logic                       q_push;
	logic                       q_full;
	logic                       q_pop;
	logic                       q_avail;
	dstwr_pkg::job_t            q_job;
	dstwr_pkg::job_t            q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_delay_q <= dstwr_pkg::REPLY_DELAY_RST;
			mm_per_tick_q <= dstwr_pkg::MM_PER_TICK_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == dstwr_pkg::REG_REPLY_DELAY) begin
				reply_delay_q <= cfg_data[dstwr_pkg::TX_W-1:0];
			end else if (cfg_index == dstwr_pkg::REG_MM_PER_TICK) begin
				mm_per_tick_q <= cfg_data[dstwr_pkg::MM_W-1:0];
			end
		end
	end

	dstwr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.reply_delay (reply_delay_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_job)
	);

	dstwr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	dstwr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.mm_per_tick  (mm_per_tick_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
